// ===== sv/partition_entry_table_defines.svh =====
// assertion macros shared by the checker
// no dependencies
`ifndef PARTITION_ENTRY_TABLE_DEFINES_SVH
`define PARTITION_ENTRY_TABLE_DEFINES_SVH
`define PET_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PET_ASSERT_NR(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ===== sv/pet_pkg.sv =====
// types and constants of the partition entry table
// no dependencies
`timescale 1ns / 1ps
package pet_pkg;
	localparam int MaxSlots = 128;
	localparam int SlotW = $clog2(MaxSlots);
	localparam int CntW = $clog2(MaxSlots + 1);
	localparam int EntryW = 448;

	typedef enum logic [1:0] {
		CMD_ADD = 2'd0, CMD_DEL = 2'd1, CMD_EDIT = 2'd2, CMD_LOOKUP = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0, ST_REVERSED = 3'd1, ST_OVERLAP = 3'd2, ST_NOT_FOUND = 3'd3,
		ST_EXISTS = 3'd4, ST_FULL = 3'd5, ST_NO_KEY = 3'd6
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR, S_IDLE, S_FIND, S_CHECK, S_WRITE, S_READ, S_OUT
	} state_t;

	typedef struct packed {
		logic [63:0] id_lo;
		logic [63:0] id_hi;
		logic [63:0] type_lo;
		logic [63:0] type_hi;
		logic [63:0] first_block;
		logic [63:0] last_block;
		logic [63:0] attributes;
	} entry_t;

	typedef struct packed {
		logic             load;
		logic             start_find;
		logic             start_check;
		logic             do_write;
		logic             do_clear_slot;
		logic             clear_sweep;
		logic             latch_read;
		logic [SlotW-1:0] addr;
		logic             scan_en;
	} dp_cmd_t;

	typedef struct packed {
		logic             hit;
		logic [SlotW-1:0] hit_slot;
		logic             overlap;
		logic             free;
		logic [SlotW-1:0] free_slot;
		logic             reversed;
		logic             new_key_zero;
		logic             key_zero;
		logic [CntW-1:0]  active;
	} dp_stat_t;
endpackage

// ===== sv/pet_ram.sv =====
// generic single port ram with registered read
// no dependencies
`timescale 1ns / 1ps
module pet_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

// ===== sv/pet_datapath.sv =====
// entry store, scan comparators and result registers
// depends on pet_pkg and pet_ram
`timescale 1ns / 1ps
module pet_datapath (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [1:0]             command,
	input  logic [127:0]           key_id,
	input  pet_pkg::entry_t        in_entry,
	input  logic [7:0]             cfg_reg,
	input  pet_pkg::dp_cmd_t       cmd,
	output pet_pkg::dp_stat_t      stat,
	output pet_pkg::entry_t        rd_entry_q
);
	pet_pkg::entry_t cmd_entry_q, ram_rd, ram_wd;
	logic [127:0] key_q;
	logic hit_q, ovl_q, free_q, pend_q, ovl_chk_q;
	logic [pet_pkg::SlotW-1:0] hit_slot_q, free_slot_q, pend_idx_q, skip_q;
	logic skip_en_q, is_edit_q;
	logic ram_we;

	always_comb begin
		ram_we = cmd.do_write | cmd.do_clear_slot | cmd.clear_sweep;
		ram_wd = cmd.do_write ? cmd_entry_q : '0;
	end

	pet_ram #(.Width(pet_pkg::EntryW), .Depth(pet_pkg::MaxSlots)) u_ram (
		.clk(clk), .we(ram_we), .addr(cmd.addr), .wdata(ram_wd), .rdata(ram_rd)
	);

	always_comb begin
		stat.hit = hit_q;
		stat.hit_slot = hit_slot_q;
		stat.overlap = ovl_q;
		stat.free = free_q;
		stat.free_slot = free_slot_q;
		stat.reversed = cmd_entry_q.last_block < cmd_entry_q.first_block;
		stat.new_key_zero = cmd_entry_q.id_lo[7:0] == 8'd0;
		stat.key_zero = key_q[7:0] == 8'd0;
		stat.active = (cfg_reg > 8'(pet_pkg::MaxSlots)) ?
			pet_pkg::CntW'(pet_pkg::MaxSlots) : pet_pkg::CntW'(cfg_reg);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
			ovl_q <= 1'b0;
			free_q <= 1'b0;
			pend_q <= 1'b0;
			hit_slot_q <= '0;
			free_slot_q <= '0;
			skip_en_q <= 1'b0;
			skip_q <= '0;
		end else begin
			pend_q <= cmd.scan_en;
			if (cmd.start_find) begin
				hit_q <= 1'b0;
				free_q <= 1'b0;
			end
			if (cmd.start_check) begin
				ovl_q <= 1'b0;
			end
			if (cmd.load) begin
				skip_en_q <= 1'b0;
			end
			if (pend_q) begin
				// find pass: lowest free, highest match (scan runs high to low)
				if (!ovl_chk_q) begin
					if ({ram_rd.id_hi, ram_rd.id_lo} == key_q && !hit_q) begin
						hit_q <= 1'b1;
						hit_slot_q <= pend_idx_q;
					end
					if (ram_rd.type_lo[7:0] == 8'd0) begin
						free_q <= 1'b1;
						free_slot_q <= pend_idx_q;
					end
				end else if (!(skip_en_q && pend_idx_q == skip_q) &&
						ram_rd.type_lo[7:0] != 8'd0 &&
						{ram_rd.id_hi, ram_rd.id_lo} !=
						{cmd_entry_q.id_hi, cmd_entry_q.id_lo} &&
						cmd_entry_q.last_block >= ram_rd.first_block &&
						cmd_entry_q.first_block <= ram_rd.last_block) begin
					ovl_q <= 1'b1;
				end
			end
			if (cmd.start_check) begin
				skip_en_q <= is_edit_q && hit_q && key_q[7:0] != 8'd0;
				skip_q <= hit_slot_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovl_chk_q <= 1'b0;
		end else if (cmd.start_find) begin
			ovl_chk_q <= 1'b0;
		end else if (cmd.start_check) begin
			ovl_chk_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		pend_idx_q <= cmd.addr;
		if (cmd.load) begin
			cmd_entry_q <= in_entry;
			is_edit_q <= command == pet_pkg::CMD_EDIT;
			key_q <= (command == pet_pkg::CMD_ADD) ?
				{in_entry.id_hi, in_entry.id_lo} : key_id;
		end
		if (cmd.start_find) begin
			rd_entry_q <= '0;
		end else if (cmd.latch_read) begin
			rd_entry_q <= ram_rd;
		end
	end
endmodule

// ===== sv/pet_ctrl.sv =====
// command sequencer of the partition entry table
// depends on pet_pkg
`timescale 1ns / 1ps
module pet_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [1:0]            command,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [2:0]            status,
	output logic [6:0]            slot,
	output logic                  show_found,
	output pet_pkg::dp_cmd_t      cmd,
	input  pet_pkg::dp_stat_t     stat
);
	pet_pkg::state_t state_q, state_d;
	logic [pet_pkg::CntW-1:0] idx_q, idx_d;
	logic [1:0] op_q;
	logic [2:0] status_q, status_d;
	logic [pet_pkg::SlotW-1:0] slot_q, slot_d;
	logic found_q, found_d, m_valid_q, m_valid_d;
	logic scan_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pet_pkg::S_CLEAR;
			idx_q <= '0;
			m_valid_q <= 1'b0;
			op_q <= pet_pkg::CMD_ADD;
			status_q <= pet_pkg::ST_OK;
			slot_q <= '0;
			found_q <= 1'b0;
			scan_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q <= idx_d;
			m_valid_q <= m_valid_d;
			status_q <= status_d;
			slot_q <= slot_d;
			found_q <= found_d;
			scan_q <= cmd.scan_en;
			if (s_tvalid && s_tready) begin
				op_q <= command;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		idx_d = idx_q;
		status_d = status_q;
		slot_d = slot_q;
		found_d = found_q;
		m_valid_d = m_valid_q && !m_tready;
		cmd = '0;
		cmd.addr = idx_q[pet_pkg::SlotW-1:0];
		s_tready = 1'b0;
		unique case (state_q)
			pet_pkg::S_CLEAR: begin
				cmd.clear_sweep = 1'b1;
				idx_d = idx_q + 1'b1;
				if (idx_q == pet_pkg::CntW'(pet_pkg::MaxSlots - 1)) begin
					state_d = pet_pkg::S_IDLE;
				end
			end
			pet_pkg::S_IDLE: begin
				s_tready = !m_valid_q || m_tready;
				if (s_tvalid && s_tready) begin
					cmd.load = 1'b1;
					cmd.start_find = 1'b1;
					idx_d = stat.active;
					state_d = pet_pkg::S_FIND;
				end
			end
			pet_pkg::S_FIND: begin
				// scan high to low, one read per cycle, then wait for the last read to be compared
				cmd.addr = pet_pkg::SlotW'(idx_q - 1'b1);
				if (idx_q != '0) begin
					cmd.scan_en = 1'b1;
					idx_d = idx_q - 1'b1;
				end else if (!scan_q) begin
					priority if (op_q == pet_pkg::CMD_ADD || op_q == pet_pkg::CMD_EDIT) begin
						cmd.start_check = 1'b1;
						idx_d = stat.active;
						state_d = pet_pkg::S_CHECK;
					end else if (stat.key_zero) begin
						status_d = pet_pkg::ST_NO_KEY;
						state_d = pet_pkg::S_OUT;
					end else if (!stat.hit) begin
						status_d = pet_pkg::ST_NOT_FOUND;
						state_d = pet_pkg::S_OUT;
					end else begin
						status_d = pet_pkg::ST_OK;
						slot_d = stat.hit_slot;
						state_d = (op_q == pet_pkg::CMD_DEL) ? pet_pkg::S_WRITE :
							pet_pkg::S_READ;
						idx_d = pet_pkg::CntW'(stat.hit_slot);
					end
				end
			end
			pet_pkg::S_CHECK: begin
				cmd.addr = pet_pkg::SlotW'(idx_q - 1'b1);
				if (idx_q != '0) begin
					cmd.scan_en = 1'b1;
					idx_d = idx_q - 1'b1;
				end else if (!scan_q) begin
					state_d = pet_pkg::S_OUT;
					priority if (stat.reversed) begin
						status_d = pet_pkg::ST_REVERSED;
					end else if (stat.overlap) begin
						status_d = pet_pkg::ST_OVERLAP;
					end else if (op_q == pet_pkg::CMD_ADD && stat.new_key_zero) begin
						status_d = pet_pkg::ST_NO_KEY;
					end else if (op_q == pet_pkg::CMD_EDIT && stat.key_zero) begin
						status_d = pet_pkg::ST_NO_KEY;
					end else if (op_q == pet_pkg::CMD_ADD && stat.hit) begin
						status_d = pet_pkg::ST_EXISTS;
					end else if (op_q == pet_pkg::CMD_ADD && !stat.free) begin
						status_d = pet_pkg::ST_FULL;
					end else if (op_q == pet_pkg::CMD_EDIT && !stat.hit) begin
						status_d = pet_pkg::ST_NOT_FOUND;
					end else begin
						status_d = pet_pkg::ST_OK;
						slot_d = (op_q == pet_pkg::CMD_ADD) ? stat.free_slot :
							stat.hit_slot;
						idx_d = pet_pkg::CntW'(slot_d);
						state_d = pet_pkg::S_WRITE;
					end
				end
			end
			pet_pkg::S_WRITE: begin
				cmd.do_write = op_q != pet_pkg::CMD_DEL;
				cmd.do_clear_slot = op_q == pet_pkg::CMD_DEL;
				state_d = pet_pkg::S_OUT;
			end
			pet_pkg::S_READ: begin
				found_d = 1'b1;
				state_d = pet_pkg::S_OUT;
			end
			pet_pkg::S_OUT: begin
				cmd.latch_read = found_q;
				m_valid_d = 1'b1;
				state_d = pet_pkg::S_IDLE;
			end
			default: state_d = pet_pkg::S_IDLE;
		endcase
		if (state_q == pet_pkg::S_IDLE && s_tvalid && s_tready) begin
			status_d = pet_pkg::ST_OK;
			slot_d = '0;
			found_d = 1'b0;
		end
		if (status_d != pet_pkg::ST_OK) begin
			slot_d = '0;
		end
	end

	assign m_tvalid = m_valid_q;
	assign status = status_q;
	assign slot = 7'(slot_q);
	assign show_found = found_q;
endmodule

// ===== sv/partition_entry_table.sv =====
// Partition entry table: 128 entries of id, type, inclusive block range and
// attributes in one RAM, cleared by a pass over every slot after reset during
// which no command is taken. Each command scans the slots in use once by id
// (one RAM read a cycle, highest slot first, then a wait for the last read to
// be compared); add and edit scan a second time for overlap. A rejected command
// skips the write or read state and goes straight to the result. The result is
// held until taken.
// depends on pet_pkg, pet_ctrl, pet_datapath, pet_ram
`timescale 1ns / 1ps
module partition_entry_table (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [7:0]   cfg_wdata,
	input  logic         s_tvalid,
	output logic         s_tready,
	// command, key_id_lo, key_id_hi, new_id_lo, new_id_hi, new_type_lo,
	// new_type_hi, new_first_block, new_last_block, new_attributes
	input  logic [583:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// status, slot, found_id_lo, found_id_hi, found_type_lo, found_type_hi,
	// found_first_block, found_last_block, found_attributes
	output logic [463:0] m_tdata
);
	logic [7:0] cfg_q;
	pet_pkg::dp_cmd_t cmd;
	pet_pkg::dp_stat_t stat;
	pet_pkg::entry_t in_entry, rd_entry;
	logic [2:0] status;
	logic [6:0] slot;
	logic show_found;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= 8'd128;
		end else if (cfg_we) begin
			cfg_q <= cfg_wdata;
		end
	end

	always_comb begin
		in_entry.id_lo = s_tdata[193:130];
		in_entry.id_hi = s_tdata[257:194];
		in_entry.type_lo = s_tdata[321:258];
		in_entry.type_hi = s_tdata[385:322];
		in_entry.first_block = s_tdata[449:386];
		in_entry.last_block = s_tdata[513:450];
		in_entry.attributes = s_tdata[577:514];
	end

	pet_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.command(s_tdata[1:0]), .m_tvalid(m_tvalid), .m_tready(m_tready),
		.status(status), .slot(slot), .show_found(show_found), .cmd(cmd), .stat(stat)
	);

	pet_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .command(s_tdata[1:0]),
		.key_id(s_tdata[129:2] == 128'd0 ? 128'd0 : {s_tdata[129:66], s_tdata[65:2]}),
		.in_entry(in_entry), .cfg_reg(cfg_q), .cmd(cmd), .stat(stat),
		.rd_entry_q(rd_entry)
	);

	assign m_tdata = {6'd0,
		show_found ? rd_entry.attributes : 64'd0,
		show_found ? rd_entry.last_block : 64'd0,
		show_found ? rd_entry.first_block : 64'd0,
		show_found ? rd_entry.type_hi : 64'd0,
		show_found ? rd_entry.type_lo : 64'd0,
		show_found ? rd_entry.id_hi : 64'd0,
		show_found ? rd_entry.id_lo : 64'd0,
		slot, status};
endmodule

// ===== sv/pet_checker.sv =====
// port level checks of the partition entry table
// depends on partition_entry_table_defines.svh
`timescale 1ns / 1ps
`include "partition_entry_table_defines.svh"
module pet_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [463:0] m_tdata
);
	`PET_ASSERT(a_hold, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")
	`PET_ASSERT(a_slot_zero, clk, arst_n, m_tvalid && m_tdata[2:0] != 3'd0 |-> m_tdata[9:3] == 7'd0, "slot set on failure")
	`PET_ASSERT(a_status, clk, arst_n, m_tvalid |-> m_tdata[2:0] != 3'd7, "bad status")
	`PET_ASSERT_NR(a_busy, clk, s_tvalid && s_tready |=> !s_tready, "second transfer taken while busy")
endmodule

bind partition_entry_table pet_checker u_pet_checker (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

// ===== sim/tb_top.sv =====
// testbench for partition_entry_table: directed and random add/delete/edit/lookup commands
// with a table predictor in a small scoreboard class, random idling on both stream sides
// depends on pet_pkg and partition_entry_table
`timescale 1ns / 1ps
module tb_top;

	class entry_scoreboard;
		pet_pkg::entry_t table_q[pet_pkg::MaxSlots];
		logic [7:0] slots_reg;
		logic [463:0] expected_q[$];
		int errors;

		function new();
			foreach (table_q[i]) table_q[i] = '0;
			slots_reg = 8'd128;
			errors = 0;
		endfunction

		function void set_slots(logic [7:0] v);
			slots_reg = v;
		endfunction

		function int active_count();
			return (slots_reg > pet_pkg::MaxSlots) ? pet_pkg::MaxSlots : int'(slots_reg);
		endfunction

		function int find_slot(logic [63:0] lo, logic [63:0] hi);
			for (int i = active_count() - 1; i >= 0; i--)
				if (table_q[i].id_lo == lo && table_q[i].id_hi == hi)
					return i;
			return -1;
		endfunction

		function pet_pkg::status_t range_status(pet_pkg::entry_t e, int skip);
			if (e.last_block < e.first_block)
				return pet_pkg::ST_REVERSED;
			for (int i = active_count() - 1; i >= 0; i--) begin
				if (i == skip || table_q[i].type_lo[7:0] == 8'h00)
					continue;
				if (table_q[i].id_lo == e.id_lo && table_q[i].id_hi == e.id_hi)
					continue;
				if (e.last_block >= table_q[i].first_block &&
						e.first_block <= table_q[i].last_block)
					return pet_pkg::ST_OVERLAP;
			end
			return pet_pkg::ST_OK;
		endfunction

		// predict the result of one accepted command transfer
		function void note_command(logic [583:0] d);
			pet_pkg::cmd_t cmd;
			logic [63:0] key_lo, key_hi;
			pet_pkg::entry_t e, found;
			pet_pkg::status_t st;
			int slot_no, hit, i;
			logic [463:0] r;
			cmd = pet_pkg::cmd_t'(d[1:0]);
			key_lo = d[65:2];
			key_hi = d[129:66];
			e.id_lo = d[193:130];
			e.id_hi = d[257:194];
			e.type_lo = d[321:258];
			e.type_hi = d[385:322];
			e.first_block = d[449:386];
			e.last_block = d[513:450];
			e.attributes = d[577:514];
			st = pet_pkg::ST_OK;
			slot_no = 0;
			found = '0;
			if (cmd == pet_pkg::CMD_ADD) begin
				st = range_status(e, -1);
				if (st == pet_pkg::ST_OK && e.id_lo[7:0] == 8'h00)
					st = pet_pkg::ST_NO_KEY;
				if (st == pet_pkg::ST_OK && find_slot(e.id_lo, e.id_hi) >= 0)
					st = pet_pkg::ST_EXISTS;
				if (st == pet_pkg::ST_OK) begin
					for (i = 0; i < active_count(); i++)
						if (table_q[i].type_lo[7:0] == 8'h00)
							break;
					if (i < active_count()) begin
						table_q[i] = e;
						slot_no = i;
					end else
						st = pet_pkg::ST_FULL;
				end
			end else if (cmd == pet_pkg::CMD_EDIT) begin
				hit = (key_lo[7:0] != 8'h00) ? find_slot(key_lo, key_hi) : -1;
				st = range_status(e, hit);
				if (st == pet_pkg::ST_OK && key_lo[7:0] == 8'h00)
					st = pet_pkg::ST_NO_KEY;
				if (st == pet_pkg::ST_OK && hit < 0)
					st = pet_pkg::ST_NOT_FOUND;
				if (st == pet_pkg::ST_OK) begin
					table_q[hit] = e;
					slot_no = hit;
				end
			end else if (key_lo[7:0] == 8'h00) begin
				st = pet_pkg::ST_NO_KEY;
			end else begin
				hit = find_slot(key_lo, key_hi);
				if (hit < 0) begin
					st = pet_pkg::ST_NOT_FOUND;
				end else begin
					slot_no = hit;
					if (cmd == pet_pkg::CMD_DEL)
						table_q[hit] = '0;
					else
						found = table_q[hit];
				end
			end
			r = '0;
			r[2:0] = st;
			r[9:3] = (st == pet_pkg::ST_OK) ? slot_no[6:0] : 7'd0;
			r[73:10] = found.id_lo;
			r[137:74] = found.id_hi;
			r[201:138] = found.type_lo;
			r[265:202] = found.type_hi;
			r[329:266] = found.first_block;
			r[393:330] = found.last_block;
			r[457:394] = found.attributes;
			expected_q.push_back(r);
		endfunction

		function void check_result(logic [463:0] got);
			logic [463:0] exp;
			int off, w;
			logic [63:0] ev, gv;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result transfer %h", $realtime, got);
				errors++;
				return;
			end
			exp = expected_q.pop_front();
			off = 0;
			for (int f = 0; f < 9; f++) begin
				w = (f == 0) ? 3 : (f == 1) ? 7 : 64;
				ev = (exp >> off) & ((65'd1 << w) - 1);
				gv = (got >> off) & ((65'd1 << w) - 1);
				if (ev !== gv) begin
					$display("%0t: field %0d mismatch expected %h actual %h",
						$realtime, f, ev, gv);
					errors++;
				end
				off += w;
			end
		endfunction
	endclass

	logic clk, arst_n, cfg_we, s_tvalid, s_tready, m_tvalid, m_tready;
	logic [7:0] cfg_wdata;
	logic [583:0] s_tdata;
	logic [463:0] m_tdata;
	bit no_idle;
	entry_scoreboard sb;
	logic [127:0] id_pool[32];

	partition_entry_table uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("Regression FAIL");
		$finish;
	end

	always @(posedge clk) begin
		if (s_tvalid && s_tready)
			sb.note_command(s_tdata);
		if (m_tvalid && m_tready)
			sb.check_result(m_tdata);
	end

	function automatic logic [63:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [583:0] pack_cmd(pet_pkg::cmd_t c, logic [127:0] key,
			logic [127:0] nid, logic [127:0] ty, logic [63:0] first, logic [63:0] last,
			logic [63:0] attr);
		return {6'd0, attr, last, first, ty[127:64], ty[63:0], nid[127:64], nid[63:0],
			key[127:64], key[63:0], c};
	endfunction

	task automatic send_cmd(logic [583:0] d);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= d;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.expected_q.size() > 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_slots(logic [7:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_slots(v);
	endtask

	task automatic send_random();
		pet_pkg::cmd_t c;
		logic [127:0] key, nid, ty;
		logic [63:0] first, last;
		int p;
		c = pet_pkg::cmd_t'($urandom_range(0, 3));
		p = $urandom_range(0, 9);
		key = (p < 8) ? id_pool[$urandom_range(0, 31)] : {rnd64(), rnd64()};
		if (p == 9) key[7:0] = 8'h00;
		p = $urandom_range(0, 9);
		nid = (p < 8) ? id_pool[$urandom_range(0, 31)] : {rnd64(), rnd64()};
		if (p == 9) nid[7:0] = 8'h00;
		if (c == pet_pkg::CMD_EDIT && $urandom_range(0, 2) == 0) nid = key;
		ty = {rnd64(), rnd64()};
		if ($urandom_range(0, 9) == 0) ty[7:0] = 8'h00;
		else if (ty[7:0] == 8'h00) ty[7:0] = 8'h5a;
		p = $urandom_range(0, 19);
		if (p < 17) begin
			first = $urandom_range(0, 600);
			last = first + $urandom_range(0, 6);
		end else if (p == 17) begin
			last = $urandom_range(0, 600);
			first = last + $urandom_range(1, 5);
		end else begin
			first = rnd64();
			last = rnd64();
		end
		send_cmd(pack_cmd(c, key, nid, ty, first, last, rnd64()));
	endtask

	initial begin
		logic [127:0] a, b;
		logic [7:0] limits[9];
		sb = new();
		limits = '{8'd128, 8'd1, 8'd0, 8'd5, 8'd255, 8'd129, 8'd64, 8'd200, 8'd20};
		foreach (id_pool[i]) begin
			id_pool[i] = {rnd64(), rnd64()};
			if (id_pool[i][7:0] == 8'h00) id_pool[i][7:0] = 8'h01;
		end
		arst_n = 0;
		cfg_we = 0;
		cfg_wdata = '0;
		s_tvalid = 0;
		s_tdata = '0;
		m_tready = 0;
		no_idle = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		fork
			forever begin
				int gap;
				gap = no_idle ? 0 : $urandom_range(0, 4);
				if (gap > 0) begin
					m_tready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				m_tready <= 1'b1;
				do @(posedge clk); while (!m_tvalid);
			end
		join_none

		a = id_pool[0];
		b = id_pool[1];
		// directed: reversed range, missing keys, extremes, exists, overlap, edits, deletes
		send_cmd(pack_cmd(pet_pkg::CMD_ADD, '0, a, {64'h1, 64'h11}, 64'd10, 64'd9, '0));
		send_cmd(pack_cmd(pet_pkg::CMD_ADD, '0, {a[127:8], 8'h00}, {64'h1, 64'h11}, 0, 5,
			'0));
		send_cmd(pack_cmd(pet_pkg::CMD_ADD, '0, a, {64'h1, 64'h11}, 64'd0, 64'd0, '1));
		send_cmd(pack_cmd(pet_pkg::CMD_ADD, '0, {128{1'b1}}, '1, '1, '1, '0));
		send_cmd(pack_cmd(pet_pkg::CMD_ADD, '0, a, {64'h2, 64'h22}, 64'd100, 64'd200, '0));
		send_cmd(pack_cmd(pet_pkg::CMD_ADD, '0, b, {64'h2, 64'h22}, 64'd0, 64'd3, '0));
		send_cmd(pack_cmd(pet_pkg::CMD_ADD, '0, b, {64'h2, 64'h22}, 64'd1, 64'd50, 64'h55));
		send_cmd(pack_cmd(pet_pkg::CMD_ADD, '0, id_pool[2], {64'h3, 64'h33}, 64'd50,
			64'd60, '0));
		send_cmd(pack_cmd(pet_pkg::CMD_LOOKUP, a, '0, '0, '0, '0, '0));
		send_cmd(pack_cmd(pet_pkg::CMD_LOOKUP, {128{1'b1}}, '0, '0, '0, '0, '0));
		send_cmd(pack_cmd(pet_pkg::CMD_LOOKUP, {a[127:8], 8'h00}, '0, '0, '0, '0, '0));
		send_cmd(pack_cmd(pet_pkg::CMD_LOOKUP, id_pool[3], '0, '0, '0, '0, '0));
		send_cmd(pack_cmd(pet_pkg::CMD_EDIT, b, b, {64'h4, 64'h44}, 64'd5, 64'd49,
			64'h77));
		send_cmd(pack_cmd(pet_pkg::CMD_EDIT, b, id_pool[4], {64'h4, 64'h44}, 64'd55,
			64'd70, '0));
		send_cmd(pack_cmd(pet_pkg::CMD_EDIT, {b[127:8], 8'h00}, b, {64'h4, 64'h44},
			64'd900, 64'd901, '0));
		send_cmd(pack_cmd(pet_pkg::CMD_EDIT, id_pool[5], b, {64'h4, 64'h44}, 64'd900,
			64'd901, '0));
		send_cmd(pack_cmd(pet_pkg::CMD_EDIT, id_pool[2], id_pool[2], {64'h4, 64'h00},
			64'd0, 64'd0, '0));
		send_cmd(pack_cmd(pet_pkg::CMD_LOOKUP, id_pool[2], '0, '0, '0, '0, '0));
		send_cmd(pack_cmd(pet_pkg::CMD_DEL, {128{1'b1}}, '0, '0, '0, '0, '0));
		send_cmd(pack_cmd(pet_pkg::CMD_DEL, {128{1'b1}}, '0, '0, '0, '0, '0));
		send_cmd(pack_cmd(pet_pkg::CMD_DEL, {b[127:8], 8'h00}, '0, '0, '0, '0, '0));
		send_cmd(pack_cmd(pet_pkg::CMD_LOOKUP, b, '0, '0, '0, '0, '0));
		drain();

		foreach (limits[k]) begin
			write_slots(limits[k]);
			no_idle = (k % 3 == 2);
			repeat (153) send_random();
			drain();
		end

		if (sb.errors == 0 && sb.expected_q.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule
